[src/ytpq_pkg.sv]
package ytpq_pkg;

   // Default grid size
   localparam int DEF_MAX_ROWS = 16;
   localparam int DEF_MAX_COLS = 16;

   // Field widths
   localparam int KEY_W     = 32;
   localparam int DIM_W     = 5;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   // Empty cell marker (largest signed key)
   localparam logic [KEY_W-1:0] EMPTY_KEY = 32'h7FFF_FFFF;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHECK,
      ST_READ_B,
      ST_DECIDE,
      ST_CLEAR,
      ST_DONE
   } state_type;

endpackage

[src/ytpq_ram.sv]
module ytpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rdata = rd_data_ff;

endmodule

[src/young_tableau_priority_queue.sv]
// Young tableau priority queue. Keeps up to MAX_ROWS x MAX_COLS signed 32-bit
// keys in one single-port-read / single-port-write RAM, each row and column
// sorted ascending, empty cells holding 0x7FFFFFFF. Only the top-left
// rows_in_use x cols_in_use sub-grid is used (0 acts as 1, values above the
// maximum act as the maximum); set the sizes only while the block is idle.
// op 0 inserts req_key_in (status 2 and no change when the bottom-right cell
// is occupied), op 1 returns the minimum in rsp_key_out (status 1 and
// 0x7FFFFFFF when empty), op 2 empties the whole store, op 3 does nothing.
// Every transfer on req_ gives exactly one transfer on rsp_. One item is
// worked at a time; the result sits in an output register, so the next item
// can be taken while the previous result waits. Each sift step is a RAM
// round (read one neighbor, then read the other and write back) that moves
// the key or hole one cell. A refused insert or an empty extract ends after
// the check of the start cell, op 2 sweeps every cell to empty, and op 3
// goes straight to the response. req_ready returns in the same cycle that
// the result is loaded into the output register; the load waits while an
// earlier result still waits for rsp_ready. After reset the RAM is swept to
// empty, one cell per cycle, before the first transfer is accepted; csr
// writes are taken throughout.
module young_tableau_priority_queue #(
   parameter int MAX_ROWS = ytpq_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = ytpq_pkg::DEF_MAX_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ytpq_pkg::OP_W-1:0]           req_op,
   input  logic signed [ytpq_pkg::KEY_W-1:0]   req_key_in,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ytpq_pkg::KEY_W-1:0]   rsp_key_out,
   output logic [ytpq_pkg::STATUS_W-1:0]       rsp_status,
   // configuration writes
   input  logic                                csr_we,
   input  logic [ytpq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ytpq_pkg::DIM_W-1:0]          csr_wdata
);

   import ytpq_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   // ---------------------------------------------------------------------
   // Address helpers
   // ---------------------------------------------------------------------
   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
      cell_addr = AW'(int'(r) * MAX_COLS) + AW'(c);
   endfunction

   // Neighbor A is up (insert) or down (extract); neighbor B is left or right.
   // A missing neighbor reads the cell itself; its value is masked later.
   function automatic logic [AW-1:0] nbr_addr(input logic          ins,
                                               input logic          use_b,
                                               input logic [RW-1:0] r,
                                               input logic [CW-1:0] c,
                                               input logic [RW-1:0] lr,
                                               input logic [CW-1:0] lc);
      logic [RW-1:0] nr;
      logic [CW-1:0] nc;
      nr = r;
      nc = c;
      if (ins) begin
         if (!use_b && r != '0) nr = r - RW'(1);
         if (use_b && c != '0)  nc = c - CW'(1);
      end else begin
         if (!use_b && r != lr) nr = r + RW'(1);
         if (use_b && c != lc)  nc = c + CW'(1);
      end
      nbr_addr = cell_addr(nr, nc);
   endfunction

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [DIM_W-1:0]    rows_cfg_ff, rows_cfg_in;
   logic [DIM_W-1:0]    cols_cfg_ff, cols_cfg_in;

   logic [OP_W-1:0]     op_ff, op_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [RW-1:0]       lr_ff, lr_in;        // last used row
   logic [CW-1:0]       lc_ff, lc_in;        // last used column
   logic [RW-1:0]       row_ff, row_in;      // current key / hole position
   logic [CW-1:0]       col_ff, col_in;
   logic signed [KEY_W-1:0] a_ff, a_in;      // neighbor A value
   logic [AW-1:0]       clr_cnt_ff, clr_cnt_in;

   logic signed [KEY_W-1:0] res_key_ff, res_key_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   // RAM port
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [KEY_W-1:0]  ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [KEY_W-1:0]  ram_rdata;
   logic signed [KEY_W-1:0] rd_key;

   // Decode
   logic              is_ins;
   logic [RW-1:0]     lr_new;
   logic [CW-1:0]     lc_new;
   logic              has_a, has_b;
   logic              ins_a_ok, ins_b_ok;
   logic signed [KEY_W-1:0] ext_a, ext_b;
   logic              move, move_a;
   logic signed [KEY_W-1:0] wr_val;
   logic              clr_last;
   logic              out_free;

   assign rd_key   = ram_rdata;
   assign is_ins   = (op_ff == OP_INSERT);
   assign clr_last = (clr_cnt_ff == AW'(DEPTH - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------
   // Storage
   // ---------------------------------------------------------------------
   ytpq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // Configuration and size clamping
   // ---------------------------------------------------------------------
   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROWS: rows_cfg_in = csr_wdata;
            CSR_COLS: cols_cfg_in = csr_wdata;
            default:  ;
         endcase
      end
   end

   always_comb begin
      if (rows_cfg_ff == '0) begin
         lr_new = '0;
      end else if (int'(rows_cfg_ff) > MAX_ROWS) begin
         lr_new = RW'(MAX_ROWS - 1);
      end else begin
         lr_new = RW'(rows_cfg_ff - DIM_W'(1));
      end
      if (cols_cfg_ff == '0) begin
         lc_new = '0;
      end else if (int'(cols_cfg_ff) > MAX_COLS) begin
         lc_new = CW'(MAX_COLS - 1);
      end else begin
         lc_new = CW'(cols_cfg_ff - DIM_W'(1));
      end
   end

   // ---------------------------------------------------------------------
   // Sift step decision. a_ff holds neighbor A, the RAM output neighbor B.
   // Insert moves the larger neighbor into the hole (up on a tie); extract
   // pulls the smaller one (down on a tie), missing neighbors count as empty.
   // ---------------------------------------------------------------------
   always_comb begin
      has_a    = is_ins ? (row_ff != '0) : (row_ff != lr_ff);
      has_b    = is_ins ? (col_ff != '0) : (col_ff != lc_ff);
      ext_a    = has_a ? a_ff : EMPTY_KEY;
      ext_b    = has_b ? rd_key : EMPTY_KEY;
      ins_a_ok = has_a && (a_ff > key_ff);
      ins_b_ok = has_b && (rd_key > key_ff);
      if (is_ins) begin
         move   = ins_a_ok || ins_b_ok;
         move_a = ins_a_ok && (!ins_b_ok || !(a_ff < rd_key));
      end else begin
         move   = !((ext_a == EMPTY_KEY) && (ext_b == EMPTY_KEY));
         move_a = !(ext_a > ext_b);
      end
      if (move) begin
         wr_val = move_a ? ext_a : ext_b;
      end else begin
         wr_val = is_ins ? key_ff : EMPTY_KEY;
      end
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_INSERT:  state_in = ST_CHECK;
                  OP_EXTRACT: state_in = ST_CHECK;
                  OP_CLEAR:   state_in = ST_CLEAR;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_CHECK: begin
            if (is_ins) begin
               state_in = (ram_rdata != EMPTY_KEY) ? ST_DONE : ST_READ_B;
            end else begin
               state_in = (ram_rdata == EMPTY_KEY) ? ST_DONE : ST_READ_B;
            end
         end
         ST_READ_B: state_in = ST_DECIDE;
         ST_DECIDE: state_in = move ? ST_READ_B : ST_DONE;
         ST_CLEAR: begin
            if (clr_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath and RAM control. The write in ST_DECIDE goes to the current
   // cell, the read to a neighbor of the next cell; they share an entry
   // only when nothing moves and the read is unused. No forwarding is needed.
   // ---------------------------------------------------------------------
   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      lr_in         = lr_ff;
      lc_in         = lc_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      a_in          = a_ff;
      clr_cnt_in    = clr_cnt_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = cell_addr(row_ff, col_ff);
      ram_wdata     = wr_val;
      ram_raddr     = nbr_addr(is_ins, 1'b0, row_ff, col_ff, lr_ff, lc_ff);

      case (state_ff)
         ST_INIT: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = EMPTY_KEY;
            clr_cnt_in = clr_cnt_ff + AW'(1);
         end
         ST_IDLE: begin
            // start cell: bottom-right for insert, top-left otherwise
            if (req_op == OP_INSERT) begin
               row_in = lr_new;
               col_in = lc_new;
            end else begin
               row_in = '0;
               col_in = '0;
            end
            ram_raddr = cell_addr(row_in, col_in);
            if (req_valid) begin
               op_in         = req_op;
               key_in        = req_key_in;
               lr_in         = lr_new;
               lc_in         = lc_new;
               clr_cnt_in    = '0;
               res_key_in    = EMPTY_KEY;
               res_status_in = STATUS_OK;
            end else begin
               row_in = row_ff;
               col_in = col_ff;
            end
         end
         ST_CHECK: begin
            if (is_ins) begin
               if (ram_rdata != EMPTY_KEY) res_status_in = STATUS_FULL;
            end else if (ram_rdata == EMPTY_KEY) begin
               res_status_in = STATUS_EMPTY;
            end else begin
               res_key_in = rd_key;
            end
         end
         ST_READ_B: begin
            a_in      = rd_key;
            ram_raddr = nbr_addr(is_ins, 1'b1, row_ff, col_ff, lr_ff, lc_ff);
         end
         ST_DECIDE: begin
            ram_we = 1'b1;
            if (move) begin
               if (move_a) begin
                  row_in = is_ins ? (row_ff - RW'(1)) : (row_ff + RW'(1));
               end else begin
                  col_in = is_ins ? (col_ff - CW'(1)) : (col_ff + CW'(1));
               end
            end
            ram_raddr = nbr_addr(is_ins, 1'b0, row_in, col_in, lr_ff, lc_ff);
         end
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = EMPTY_KEY;
            clr_cnt_in = clr_cnt_ff + AW'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_key_in    = res_key_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rows_cfg_ff  <= DIM_RESET;
         cols_cfg_ff  <= DIM_RESET;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      lr_ff         <= lr_in;
      lc_ff         <= lc_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      a_ff          <= a_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_key_out = rsp_key_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

[tb/tb_young_tableau_priority_queue.sv]
`timescale 1ns / 1ps

module tb_young_tableau_priority_queue;
   import ytpq_pkg::*;

   // grid size of the instance (package defaults)
   localparam int GRID_ROWS = DEF_MAX_ROWS;
   localparam int GRID_COLS = DEF_MAX_COLS;
   localparam int CYCLE_LIMIT = 3_000_000;
   // op code 3 has no meaning; the block must answer it and change nothing
   localparam logic [OP_W-1:0] OP_NOP = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic signed [KEY_W-1:0] key;
   } tq_req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [STATUS_W-1:0]     status;
   } tq_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [OP_W-1:0]         req_op = OP_INSERT;
   logic signed [KEY_W-1:0] req_key_in = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [KEY_W-1:0] rsp_key_out;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_ROWS;
   logic [DIM_W-1:0]        csr_wdata = '0;

   // items waiting to be driven, and replies owed by the block in order
   tq_req_type op_backlog[$];
   tq_rsp_type predicted_replies[$];

   // shadow tableau and shadow size registers
   logic signed [KEY_W-1:0] tableau[GRID_ROWS*GRID_COLS];
   logic [DIM_W-1:0]        rows_cfg = DIM_RESET;
   logic [DIM_W-1:0]        cols_cfg = DIM_RESET;

   // idle percentages for each side, changed per phase
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   young_tableau_priority_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_key_in  (req_key_in),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_key_out (rsp_key_out),
      .rsp_status  (rsp_status),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Tableau predictor
   // ------------------------------------------------------------------

   // 0 acts as 1, anything above the grid size acts as the grid size
   function automatic int dim_used(logic [DIM_W-1:0] v, int limit);
      if (v == 0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic int slot(int r, int c);
      return r * GRID_COLS + c;
   endfunction

   // new key enters bottom-right of the sub-grid and bubbles up/left
   function automatic bit tableau_insert(logic signed [KEY_W-1:0] key);
      int i;
      int j;
      bit up_ok;
      bit left_ok;
      bit go_up;
      bit settled;
      logic signed [KEY_W-1:0] hold;
      i = dim_used(rows_cfg, GRID_ROWS) - 1;
      j = dim_used(cols_cfg, GRID_COLS) - 1;
      if (tableau[slot(i, j)] != EMPTY_KEY) return 1'b0;
      tableau[slot(i, j)] = key;
      settled = 1'b0;
      while (!settled) begin
         up_ok = (i > 0) && (tableau[slot(i - 1, j)] > key);
         left_ok = (j > 0) && (tableau[slot(i, j - 1)] > key);
         if (!up_ok && !left_ok) begin
            settled = 1'b1;
         end else begin
            // both larger: move toward the larger one, up on a tie
            if (up_ok && left_ok)
               go_up = !(tableau[slot(i - 1, j)] < tableau[slot(i, j - 1)]);
            else
               go_up = up_ok;
            if (go_up) begin
               hold = tableau[slot(i - 1, j)];
               tableau[slot(i - 1, j)] = tableau[slot(i, j)];
               tableau[slot(i, j)] = hold;
               i--;
            end else begin
               hold = tableau[slot(i, j - 1)];
               tableau[slot(i, j - 1)] = tableau[slot(i, j)];
               tableau[slot(i, j)] = hold;
               j--;
            end
         end
      end
      return 1'b1;
   endfunction

   // hole left at top-left walks toward the smaller neighbor, down on a tie;
   // neighbors past the sub-grid edge count as empty
   function automatic void tableau_extract();
      int i;
      int j;
      int nr;
      int nc;
      bit settled;
      logic signed [KEY_W-1:0] down;
      logic signed [KEY_W-1:0] right;
      nr = dim_used(rows_cfg, GRID_ROWS);
      nc = dim_used(cols_cfg, GRID_COLS);
      i = 0;
      j = 0;
      settled = 1'b0;
      while (!settled) begin
         down = (i + 1 < nr) ? tableau[slot(i + 1, j)] : EMPTY_KEY;
         right = (j + 1 < nc) ? tableau[slot(i, j + 1)] : EMPTY_KEY;
         if (down == EMPTY_KEY && right == EMPTY_KEY) begin
            tableau[slot(i, j)] = EMPTY_KEY;
            settled = 1'b1;
         end else if (down > right) begin
            tableau[slot(i, j)] = right;
            j++;
         end else begin
            tableau[slot(i, j)] = down;
            i++;
         end
      end
   endfunction

   function automatic tq_rsp_type tableau_apply(logic [OP_W-1:0] op,
                                                 logic signed [KEY_W-1:0] key);
      tq_rsp_type r;
      r.key = EMPTY_KEY;
      r.status = STATUS_OK;
      case (op)
         OP_INSERT: begin
            if (!tableau_insert(key)) r.status = STATUS_FULL;
         end
         OP_EXTRACT: begin
            if (tableau[0] == EMPTY_KEY) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.key = tableau[0];
               tableau_extract();
            end
         end
         OP_CLEAR: begin
            foreach (tableau[k]) tableau[k] = EMPTY_KEY;
         end
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: holds payload until transfer, predicts on transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      tq_req_type nxt;
      tq_rsp_type owed;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            owed = tableau_apply(req_op, req_key_in);
            predicted_replies = {predicted_replies, owed};
         end
         if (!req_valid || req_ready) begin
            if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = op_backlog.pop_front();
               req_valid <= 1'b1;
               req_op <= nxt.op;
               req_key_in <= nxt.key;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: random back-pressure, in-order compare
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      tq_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected transfer key_out=%0d status=%0d",
                           $realtime, rsp_key_out, rsp_status);
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_key_out !== want.key || rsp_status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch key_out exp %0d got %0d, status exp %0d got %0d",
                              $realtime, want.key, rsp_key_out, want.status, rsp_status);
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic push_item(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
      tq_req_type it;
      it.op = op;
      it.key = key;
      op_backlog = {op_backlog, it};
   endtask

   // block idle: nothing queued, nothing offered, nothing owed
   task automatic wait_drained();
      @(negedge clock);
      while (op_backlog.size() != 0 || req_valid || predicted_replies.size() != 0)
         @(negedge clock);
   endtask

   // size writes only while idle; shadow copy follows each write
   task automatic write_dims(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
      wait_drained();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_wdata <= rows;
      rows_cfg = rows;
      @(posedge clock);
      csr_index <= CSR_COLS;
      csr_wdata <= cols;
      cols_cfg = cols;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // mostly small grids; out-of-range codes and the full size now and then
   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return DIM_RESET;
         3: return DIM_W'($urandom_range(0, 31));
         default: return DIM_W'($urandom_range(1, 5));
      endcase
   endfunction

   // narrow range for ties, full range for bit coverage, plus extremes
   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3, 4, 5, 6: return $signed(KEY_W'($urandom_range(0, 20))) - 10;
         7: return 32'sh8000_0000;
         8: return 32'sh7FFF_FFFE;
         default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0001;
      endcase
   endfunction

   // alternating fill and drain bursts so the grid fills up and empties
   task automatic queue_bursts(int count);
      int left;
      int len;
      int roll;
      bit filling;
      logic [OP_W-1:0] op;
      left = count;
      while (left > 0) begin
         filling = $urandom_range(0, 1);
         len = $urandom_range(4, 30);
         for (int k = 0; k < len && left > 0; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 75 : 20)) op = OP_INSERT;
            else if (roll < 96) op = OP_EXTRACT;
            else if (roll < 98) op = OP_CLEAR;
            else op = OP_NOP;
            push_item(op, pick_key());
            left--;
         end
      end
   endtask

   initial begin
      foreach (tableau[k]) tableau[k] = EMPTY_KEY;
      send_idle_pct = 18;
      recv_stall_pct = 68;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset size 16 x 16, empty extract, key extremes,
      // the empty value itself, ties, unused op, clear
      push_item(OP_EXTRACT, 32'sd0);
      push_item(OP_INSERT, 32'sh8000_0000);
      push_item(OP_INSERT, 32'sh7FFF_FFFE);
      push_item(OP_INSERT, 32'sh7FFF_FFFF);
      push_item(OP_INSERT, -32'sd1);
      push_item(OP_INSERT, 32'sd0);
      push_item(OP_INSERT, 32'sd0);
      push_item(OP_NOP, 32'sh5A5A_A5A5);
      repeat (3) push_item(OP_EXTRACT, 32'sd0);
      push_item(OP_CLEAR, 32'sd0);
      push_item(OP_EXTRACT, 32'sd0);

      // rows code 0 acts as one row: 1 x 1 grid, full after one insert
      write_dims('0, 5'd1);
      push_item(OP_INSERT, 32'sd5);
      push_item(OP_INSERT, 32'sd6);
      push_item(OP_EXTRACT, 32'sd0);
      push_item(OP_EXTRACT, 32'sd0);

      // rows code above range clamps to 16: tall narrow grid with ties
      write_dims('1, 5'd2);
      push_item(OP_INSERT, 32'sd7);
      push_item(OP_INSERT, 32'sd7);
      push_item(OP_INSERT, 32'sd3);
      push_item(OP_INSERT, 32'sd7);
      push_item(OP_INSERT, -32'sd4);
      repeat (3) push_item(OP_EXTRACT, 32'sd0);

      // random: three idle profiles, four grid sizes each, keys carried
      // across size changes on purpose
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 18; recv_stall_pct = 68; end
            1: begin send_idle_pct = 68; recv_stall_pct = 18; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            if (seg == 0) begin
               case (phase)
                  0: write_dims(5'd1, DIM_RESET);
                  1: write_dims(DIM_RESET, 5'd1);
                  default: write_dims(DIM_RESET, DIM_RESET);
               endcase
            end else begin
               write_dims(pick_dim(), pick_dim());
            end
            queue_bursts(146);
         end
      end

      wait_drained();
      // room for a stray late transfer (a clear sweeps the whole store)
      repeat (300) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
